FILE: src/circular_fifo_queue_core_macros.svh
// Assertion macros shared by the queue design.
`ifndef CIRCULAR_FIFO_QUEUE_CORE_MACROS_SVH
`define CIRCULAR_FIFO_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CFQ_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed: label");
`define CFQ_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed: label");
`else
`define CFQ_ASSERT_IMPL(label, clk, rst_n, lhs, rhs)
`define CFQ_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

FILE: src/cfq_pkg.sv
// Package with the types and constants of the circular queue.
`timescale 1ns / 1ps

package cfq_pkg;

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_DISPLAY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic    load;
    status_t status;
    logic    last;
    logic    use_mem;
  } out_ctl_t;

endpackage

FILE: src/cfq_ram.sv
// Entry storage: one write port and one registered read port.
`timescale 1ns / 1ps

module cfq_ram #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/cfq_ctrl.sv
// Queue controller: pointers, occupancy, capacity register and display walk.
`timescale 1ns / 1ps

module cfq_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [31:0]                 in_value,
  input  logic                        cfg_wr_en,
  input  logic [cfq_pkg::CAP_W-1:0]   cfg_wr_data,
  input  logic                        out_free,
  output cfq_pkg::out_ctl_t           out_ctl,
  output logic                        wr_en,
  output logic [IDX_W-1:0]            wr_addr,
  output logic [DATA_WIDTH-1:0]       wr_data,
  output logic                        rd_en,
  output logic [IDX_W-1:0]            rd_addr
);

  localparam logic [31:0] DEPTH_W = 32'(DEPTH);

  cfq_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [IDX_W-1:0] walk_r, walk_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic [cfq_pkg::CAP_W-1:0] capacity_r;
  logic [31:0] cap32;
  logic [CNT_W-1:0] cap_eff;
  logic accept;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] n;
    n = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
    return (n >= {1'b0, cap}) ? '0 : IDX_W'(n);
  endfunction

  assign cap32   = {{(32-cfq_pkg::CAP_W){1'b0}}, capacity_r};
  assign cap_eff = (capacity_r == '0) ? CNT_W'(1) :
                   (cap32 > DEPTH_W) ? CNT_W'(DEPTH) : CNT_W'(cap32);

  assign in_stall = !((state_r == cfq_pkg::S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfq_pkg::S_IDLE: begin
        if (accept && occ_r != '0 &&
            (in_operation == cfq_pkg::OP_DELETE || in_operation == cfq_pkg::OP_DISPLAY)) begin
          state_nxt = cfq_pkg::S_READ;
        end
      end
      cfq_pkg::S_READ: begin
        if (out_free && remain_r == CNT_W'(1)) begin
          state_nxt = cfq_pkg::S_IDLE;
        end
      end
      default: state_nxt = cfq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    walk_nxt   = walk_r;
    occ_nxt    = occ_r;
    remain_nxt = remain_r;
    out_ctl    = '{load: 1'b0, status: cfq_pkg::ST_OK, last: 1'b1, use_mem: 1'b0};
    wr_en      = 1'b0;
    wr_addr    = tail_r;
    wr_data    = DATA_WIDTH'(in_value);
    rd_en      = 1'b0;
    rd_addr    = head_r;
    case (state_r)
      cfq_pkg::S_IDLE: begin
        if (accept) begin
          case (in_operation)
            cfq_pkg::OP_INSERT: begin
              out_ctl.load = 1'b1;
              if (occ_r >= cap_eff) begin
                out_ctl.status = cfq_pkg::ST_OVERFLOW;
              end else begin
                wr_en    = 1'b1;
                tail_nxt = advance(tail_r, cap_eff);
                occ_nxt  = occ_r + CNT_W'(1);
              end
            end
            cfq_pkg::OP_DELETE: begin
              if (occ_r == '0) begin
                out_ctl.load   = 1'b1;
                out_ctl.status = cfq_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                head_nxt   = advance(head_r, cap_eff);
                occ_nxt    = occ_r - CNT_W'(1);
                remain_nxt = CNT_W'(1);
              end
            end
            cfq_pkg::OP_DISPLAY: begin
              if (occ_r == '0) begin
                out_ctl.load   = 1'b1;
                out_ctl.status = cfq_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                walk_nxt   = advance(head_r, cap_eff);
                remain_nxt = occ_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      cfq_pkg::S_READ: begin
        rd_addr = walk_r;
        if (out_free) begin
          out_ctl.load    = 1'b1;
          out_ctl.use_mem = 1'b1;
          out_ctl.last    = (remain_r == CNT_W'(1));
          if (remain_r != CNT_W'(1)) begin
            rd_en      = 1'b1;
            walk_nxt   = advance(walk_r, cap_eff);
            remain_nxt = remain_r - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cfq_pkg::S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      walk_r     <= '0;
      occ_r      <= '0;
      remain_r   <= '0;
      capacity_r <= cfq_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      state_r    <= state_nxt;
      head_r     <= '0;
      tail_r     <= '0;
      walk_r     <= walk_nxt;
      occ_r      <= '0;
      remain_r   <= remain_nxt;
      capacity_r <= cfg_wr_data;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      walk_r     <= walk_nxt;
      occ_r      <= occ_nxt;
      remain_r   <= remain_nxt;
    end
  end

endmodule

FILE: src/circular_fifo_queue_core.sv
// Top level of the circular queue: controller, storage and output register.
// An insert goes straight to the output register; a delete first reads the entry
// from the memory's registered read port. A display of n stored words reads them
// one word per cycle from the same read port while the output is not stalled.
// Results leave through an output register. Synchronous active-low reset empties
// the queue and sets the capacity to 16; the stored words themselves are not cleared.
`timescale 1ns / 1ps
`include "circular_fifo_queue_core_macros.svh"

module circular_fifo_queue_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_operation,
  input  logic signed [31:0]        in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic signed [31:0]        out_data,
  output logic                      out_last,
  input  logic                      cfg_wr_en,
  input  logic [cfq_pkg::CAP_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cfq_pkg::out_ctl_t out_ctl;
  logic out_free;
  logic wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;
  logic signed [DATA_WIDTH-1:0] rd_signed;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_data_r;
  logic        out_last_r;

  assign out_free = !out_valid_r || !out_stall;

  cfq_ctrl #(
    .DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .IDX_W(IDX_W), .CNT_W(CNT_W)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_value(in_value),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_free(out_free), .out_ctl(out_ctl),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr)
  );

  cfq_ram #(
    .DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .IDX_W(IDX_W)
  ) u_ram (
    .clk(clk),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign rd_signed = rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ctl.load) begin
      out_status_r <= out_ctl.status;
      out_data_r   <= out_ctl.use_mem ? 32'(rd_signed) : '0;
      out_last_r   <= out_ctl.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

  `CFQ_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_valid_r && out_stall, !out_ctl.load)
  `CFQ_ASSERT_IMPL(a_port_exclusive, clk, rst_n, wr_en, !rd_en)
  `CFQ_ASSERT_IMPL(a_error_single, clk, rst_n, out_ctl.load && out_ctl.status != cfq_pkg::ST_OK, out_ctl.last && !out_ctl.use_mem)
  `CFQ_ASSERT_NEXT(a_read_then_busy, clk, rst_n, rd_en && !cfg_wr_en, in_stall || out_valid_r)

endmodule
